// ===== design/u2d_pkg.sv =====
// ----------------------------------------------------------------------------
// u2d_pkg
// shared types and constants of the utf-8 to dta transcoder
// ----------------------------------------------------------------------------
package u2d_pkg;

  localparam logic [6:0] SPACE_CHAR = 7'h20;

  // output queue depth, at least two so one byte can always push its results
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // one dta character word
  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } u2d_word_t;

  // results released by one decoded byte, first word in w0
  typedef struct packed {
    logic [1:0] count;
    u2d_word_t  w0;
    u2d_word_t  w1;
  } u2d_result_t;

  // queue status towards the input side
  typedef struct packed {
    logic room;
    logic empty;
  } u2d_queue_status_t;

endpackage

// ===== design/u2d_decoder.sv =====
// ----------------------------------------------------------------------------
// u2d_decoder
// byte classifier and sequence state, releases up to two characters per byte
// ----------------------------------------------------------------------------
module u2d_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output u2d_pkg::u2d_result_t result
);
  import u2d_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LEAD = 2'd1,
    MODE_PAIR = 2'd2,
    MODE_SKIP = 2'd3
  } mode_t;

  mode_t      mode, mode_next;
  logic [6:0] pending, pending_next;

  function automatic logic [6:0] map_ascii(input logic [6:0] b);
    logic [6:0] u;
    logic [6:0] r;
    u = b;
    if (b >= 7'h61 && b <= 7'h7a) u = b - 7'h20;
    r = SPACE_CHAR;
    if ((u >= 7'h30 && u <= 7'h39) || (u >= 7'h41 && u <= 7'h5a)) r = u;
    case (u)
      7'h20, 7'h2e, 7'h2c, 7'h26, 7'h2d, 7'h2b, 7'h2a, 7'h25, 7'h2f, 7'h24: r = u;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] map_second(input logic [7:0] b);
    logic [6:0] r;
    case (b)
      8'h84, 8'ha4: r = 7'h5b;
      8'h96, 8'hb6: r = 7'h5c;
      8'h9c, 8'hbc: r = 7'h5d;
      8'h9f:        r = 7'h7e;
      default:      r = SPACE_CHAR;
    endcase
    return r;
  endfunction

  logic is_cont, is_lead;
  assign is_cont = (in_byte[7:6] == 2'b10);
  assign is_lead = (in_byte[7:6] == 2'b11);

  always_comb begin
    logic       fresh;
    logic [1:0] n;
    u2d_word_t  w0, w1, ws;
    logic       ws_valid;
    fresh        = 1'b0;
    n            = 2'd0;
    w0           = '{char_code: SPACE_CHAR, last: 1'b0};
    w1           = '{char_code: SPACE_CHAR, last: 1'b0};
    ws           = '{char_code: SPACE_CHAR, last: 1'b0};
    ws_valid     = 1'b0;
    mode_next    = mode;
    pending_next = pending;

    case (mode)
      MODE_LEAD: begin
        if (!is_cont) begin
          n = 2'd1;
          w0 = '{char_code: SPACE_CHAR, last: in_last};
          mode_next = MODE_IDLE;
        end else if (in_last) begin
          n = 2'd1;
          w0 = '{char_code: map_second(in_byte), last: 1'b1};
          mode_next = MODE_IDLE;
        end else begin
          pending_next = map_second(in_byte);
          mode_next = MODE_PAIR;
        end
      end
      MODE_PAIR, MODE_SKIP: begin
        if (is_cont) begin
          pending_next = SPACE_CHAR;
          if (in_last) begin
            n = 2'd1;
            w0 = '{char_code: SPACE_CHAR, last: 1'b1};
            mode_next = MODE_IDLE;
          end else begin
            mode_next = MODE_SKIP;
          end
        end else begin
          n = 2'd1;
          w0 = '{char_code: pending, last: 1'b0};
          fresh = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase

    // a byte that starts a new character
    if (fresh) begin
      mode_next = MODE_IDLE;
      if (is_lead) begin
        if (in_last) begin
          ws_valid = 1'b1;
          ws = '{char_code: SPACE_CHAR, last: 1'b1};
        end else begin
          mode_next = MODE_LEAD;
        end
      end else if (is_cont) begin
        if (in_last) begin
          ws_valid = 1'b1;
          ws = '{char_code: SPACE_CHAR, last: 1'b1};
        end else begin
          pending_next = SPACE_CHAR;
          mode_next = MODE_SKIP;
        end
      end else begin
        ws_valid = 1'b1;
        ws = '{char_code: map_ascii(in_byte[6:0]), last: in_last};
      end
      if (ws_valid) begin
        if (n == 2'd0) begin
          w0 = ws;
          n = 2'd1;
        end else begin
          w1 = ws;
          n = 2'd2;
        end
      end
    end

    if (in_last) mode_next = MODE_IDLE;

    result.count = n;
    result.w0    = w0;
    result.w1    = w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      pending <= '0;
    end else if (fire) begin
      mode    <= mode_next;
      pending <= pending_next;
    end
  end

  // a string always leaves the decoder idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && in_last) |=> (mode == MODE_IDLE))
    else $error("decoder not idle after final byte");

  // two words only when a held character is flushed by a fresh byte
  a_two_from_held: assert property (@(posedge clk) disable iff (rst)
    (result.count == 2'd2) |-> (mode == MODE_PAIR || mode == MODE_SKIP))
    else $error("two words without a held character");

endmodule

// ===== design/u2d_out_queue.sv =====
// ----------------------------------------------------------------------------
// u2d_out_queue
// small word queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
module u2d_out_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  u2d_pkg::u2d_result_t     push_data,
  output u2d_pkg::u2d_queue_status_t status,
  input  logic                     pop,
  output u2d_pkg::u2d_word_t       head
);
  import u2d_pkg::*;

  u2d_word_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]       push_n;

  assign push_n       = push ? push_data.count : 2'd0;
  assign status.room  = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_comb begin
    count_next = count + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr] <= push_data.w0;
    if (push_n == 2'd2) mem[wr_ptr + PTR_W'(1)] <= push_data.w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> status.room)
    else $error("queue push without room");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue pop while empty");

endmodule

// ===== design/utf8_to_dta_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_to_dta_transcoder_unit
// utf-8 byte stream to dta banking character set
// ----------------------------------------------------------------------------
// takes one utf-8 byte per word on the slave side, s_tlast on the final byte
// of a string, and gives dta characters on the master side, m_tlast on the
// final character. one byte is taken per cycle while the queue has room:
// it lands in an input register, is decoded from there and its zero, one
// or two characters are written into a four-word output queue, whose head
// drives the master side. a byte is decoded only while the queue has room
// for two words, so the sustained rate is one byte per cycle while the
// output drains one word per cycle; a byte that flushes a held character
// as well as its own gives two words, which leave the queue in turn. a
// character whose fate depends on the next byte (the second byte of a pair,
// a run of continuation bytes) is held until that byte arrives
// ----------------------------------------------------------------------------
module utf8_to_dta_transcoder_unit (
  input  logic       clk,
  input  logic       rst,
  // slave side
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  // master side
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tlast    // out_last
);
  import u2d_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  u2d_result_t       result;
  u2d_queue_status_t qstat;
  u2d_word_t         head;
  logic              fire;
  logic              pop;

  // decode the held byte only when the queue can take both possible words
  assign fire     = in_valid && qstat.room;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  u2d_decoder u_decoder (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_byte (in_byte),
    .in_last (in_last),
    .result  (result)
  );

  assign m_tvalid = !qstat.empty;
  assign pop      = m_tvalid && m_tready;

  u2d_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (result),
    .status    (qstat),
    .pop       (pop),
    .head      (head)
  );

  assign m_tdata = {1'b0, head.char_code};
  assign m_tlast = head.last;

  // held byte stays until it is decoded
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !fire) |=> (in_valid && $stable(in_byte) && $stable(in_last)))
    else $error("input word lost before decode");

  // no byte decoded without one held
  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    fire |-> in_valid)
    else $error("decode without input word");

endmodule

// ===== tb/dta_char_checker.sv =====
// ----------------------------------------------------------------------------
// dta_char_checker
// watches both stream sides of the transcoder and checks every dta character
// ----------------------------------------------------------------------------
// each byte taken on the slave side runs through a cycle-free copy of the
// decoder, which queues the characters it releases. each word given on the
// master side is compared with the oldest queued character.
// ----------------------------------------------------------------------------
module dta_char_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [6:0] out_char, [7] zero
  input  logic        m_tlast,   // out_last
  output int unsigned fail_count,
  output int unsigned chars_awaited
);
  import u2d_pkg::*;

  typedef enum logic [1:0] {
    XLATE_IDLE = 2'd0,
    XLATE_LEAD = 2'd1,
    XLATE_PAIR = 2'd2,
    XLATE_SKIP = 2'd3
  } xlate_mode_t;

  localparam logic [7:0] CLASS_MASK = 8'hC0;
  localparam logic [7:0] CLASS_LEAD = 8'hC0;
  localparam logic [7:0] CLASS_CONT = 8'h80;

  // dta codes of the umlauts and sharp s
  localparam logic [6:0] DTA_AE = 7'h5B;
  localparam logic [6:0] DTA_OE = 7'h5C;
  localparam logic [6:0] DTA_UE = 7'h5D;
  localparam logic [6:0] DTA_SZ = 7'h7E;

  xlate_mode_t xlate_mode = XLATE_IDLE;
  logic [6:0]  held_char  = '0;
  u2d_word_t   chars_due[$];
  int unsigned mismatches = 0;

  initial begin
    fail_count    = 0;
    chars_awaited = 0;
  end

  function automatic logic [6:0] fold_ascii(input logic [7:0] b);
    logic [7:0] u;
    u = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
    if ((u >= 8'h30 && u <= 8'h39) || (u >= 8'h41 && u <= 8'h5A)) return u[6:0];
    case (u)
      " ", ".", ",", "&", "-", "+", "*", "%", "/", "$": return u[6:0];
      default: return SPACE_CHAR;
    endcase
  endfunction

  function automatic logic [6:0] fold_umlaut(input logic [7:0] b);
    case (b)
      8'h84, 8'hA4: return DTA_AE;
      8'h96, 8'hB6: return DTA_OE;
      8'h9C, 8'hBC: return DTA_UE;
      8'h9F:        return DTA_SZ;
      default:      return SPACE_CHAR;
    endcase
  endfunction

  task automatic queue_char(input logic [6:0] ch, input logic lst);
    u2d_word_t w;
    w.char_code = ch;
    w.last      = lst;
    chars_due.push_back(w);
  endtask

  // byte seen with nothing pending
  task automatic take_fresh(input logic [7:0] b, input logic lst);
    xlate_mode = XLATE_IDLE;
    if ((b & CLASS_MASK) == CLASS_LEAD) begin
      if (lst) queue_char(SPACE_CHAR, 1'b1);
      else xlate_mode = XLATE_LEAD;
    end else if ((b & CLASS_MASK) == CLASS_CONT) begin
      if (lst) begin
        queue_char(SPACE_CHAR, 1'b1);
      end else begin
        held_char  = SPACE_CHAR;
        xlate_mode = XLATE_SKIP;
      end
    end else begin
      queue_char(fold_ascii(b), lst);
    end
  endtask

  task automatic transcode_byte(input logic [7:0] b, input logic lst);
    logic cont;
    cont = (b & CLASS_MASK) == CLASS_CONT;
    case (xlate_mode)
      XLATE_LEAD: begin
        if (!cont) begin
          queue_char(SPACE_CHAR, lst);
          xlate_mode = XLATE_IDLE;
        end else if (lst) begin
          queue_char(fold_umlaut(b), 1'b1);
          xlate_mode = XLATE_IDLE;
        end else begin
          held_char  = fold_umlaut(b);
          xlate_mode = XLATE_PAIR;
        end
      end
      XLATE_PAIR, XLATE_SKIP: begin
        if (cont) begin
          // long sequence or stray run collapses to one space
          held_char = SPACE_CHAR;
          if (lst) begin
            queue_char(SPACE_CHAR, 1'b1);
            xlate_mode = XLATE_IDLE;
          end else begin
            xlate_mode = XLATE_SKIP;
          end
        end else begin
          queue_char(held_char, 1'b0);
          take_fresh(b, lst);
        end
      end
      default: take_fresh(b, lst);
    endcase
    if (lst) xlate_mode = XLATE_IDLE;
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    u2d_word_t want;
    if (rst) begin
      xlate_mode = XLATE_IDLE;
      held_char  = '0;
      chars_due.delete();
    end else begin
      if (s_tvalid && s_tready) transcode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
        end else begin
          want = chars_due.pop_front();
          if (m_tdata !== {1'b0, want.char_code})
            report_mismatch($sformatf("char %h, want %h", m_tdata, want.char_code));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b on char %h",
                                      m_tlast, want.last, want.char_code));
        end
      end
    end
    fail_count    <= mismatches;
    chars_awaited <= chars_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the utf-8 to dta transcoder
// ----------------------------------------------------------------------------
// sends a short directed set of strings covering the byte classes and the
// odd sequences, then random strings built mostly from well-formed pieces
// with noise mixed in, over phases of sender gaps and receiver stalls.
// checking is done by dta_char_checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;

  import u2d_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned LIMIT_CYCLES = 400_000;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;   // [7:0] in_byte
  logic       s_tlast  = 1'b0; // in_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;         // [6:0] out_char, [7] zero
  logic       m_tlast;         // out_last

  int unsigned fail_count;
  int unsigned chars_awaited;

  // idling odds out of a hundred, set per phase
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;

  int unsigned bytes_sent = 0;
  logic [7:0]  text_bytes[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  utf8_to_dta_transcoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  dta_char_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .chars_awaited (chars_awaited)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // one byte word; tvalid stays high when the next word follows straight on
  task automatic send_word(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // sends text_bytes as one string, tlast on the final byte, then empties it
  task automatic send_string();
    foreach (text_bytes[i]) send_word(text_bytes[i], i == text_bytes.size() - 1);
    bytes_sent += text_bytes.size();
    text_bytes.delete();
  endtask

  function automatic logic [7:0] any_cont();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  function automatic logic [7:0] any_lead();
    return 8'hC0 | 8'($urandom_range(63));
  endfunction

  // random string made of a few pieces, mostly well-formed sequences
  task automatic send_random_string();
    int unsigned pieces;
    int unsigned run;
    logic [7:0]  umlaut_tail[7];
    umlaut_tail = '{8'h84, 8'hA4, 8'h96, 8'hB6, 8'h9C, 8'hBC, 8'h9F};
    pieces = $urandom_range(1, 8);
    repeat (pieces) begin
      case ($urandom_range(9))
        0, 1, 2, 3: text_bytes.push_back(8'($urandom_range(127)));
        4, 5: begin
          // umlaut pair, sometimes with another lead byte or an unmapped continuation
          text_bytes.push_back(($urandom_range(3) == 0) ? any_lead() : 8'hC3);
          text_bytes.push_back(($urandom_range(3) == 0) ? any_cont() :
                               umlaut_tail[$urandom_range(6)]);
        end
        6: begin
          // three or four byte sequence
          run = $urandom_range(2, 3);
          text_bytes.push_back(any_lead());
          repeat (run) text_bytes.push_back(any_cont());
        end
        7: begin
          run = $urandom_range(1, 3);
          repeat (run) text_bytes.push_back(any_cont());
        end
        8: begin
          // broken pair: lead then a plain byte
          text_bytes.push_back(any_lead());
          text_bytes.push_back(8'($urandom_range(127)));
        end
        default: text_bytes.push_back(8'($urandom_range(255)));
      endcase
    end
    send_string();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ascii extremes and folding, lead as final byte
    text_bytes = '{8'h00, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h24, 8'h7F, 8'hFF};
    send_string();
    // umlaut, sharp s, lead then plain byte, three byte run, stray run,
    // lead as final byte after a held space
    text_bytes = '{8'hC3, 8'hA4, 8'hC3, 8'h9F, 8'hC3, 8'h41, 8'hE2, 8'h82, 8'hAC,
                   8'h80, 8'hBF, 8'hC3};
    send_string();
    // final byte swallowed by a long sequence
    text_bytes = '{8'h41, 8'hE2, 8'h82, 8'hAC};
    send_string();

    // random phases: no idling, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 86; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 86; end
        default: begin src_idle_pct = 25; snk_stall_pct = 25; end
      endcase
      while (bytes_sent < 24 + RANDOM_ITEMS * (phase + 1) / 4) send_random_string();
    end
    s_tvalid <= 1'b0;

    // drain, then a tail wait for anything stray
    do @(posedge clk); while (chars_awaited != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
design/u2d_pkg.sv
design/u2d_decoder.sv
design/u2d_out_queue.sv
design/utf8_to_dta_transcoder_unit.sv
tb/dta_char_checker.sv
tb/tb_top.sv
